// File: design/psp_pkg.sv
`timescale 1ns / 1ps
package psp_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_BASE_RADIUS = 3'd0;
    localparam logic [2:0] CFG_PULSE_AMP   = 3'd1;
    localparam logic [2:0] CFG_PULSE_FREQ  = 3'd2;
    localparam logic [2:0] CFG_CENTER_X    = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd4;
    localparam logic [2:0] CFG_CENTER_Z    = 3'd5;

    // CORDIC: gain-compensated 1.0 in signed Q4.30, two iterations per stage
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;

    // digit-recurrence units: two result bits per stage
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES = 16;

    // main line stage indexes
    localparam int ST_D     = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_R     = 12;
    localparam int ST_RR    = 13;
    localparam int ST_PUSH  = 14;
    localparam int ST_M     = ST_SUM + SQRT_STAGES + 1;
    localparam int ST_PROD  = ST_M + 1;
    localparam int ST_NEW   = ST_PROD + DIV_STAGES + 1;
    localparam int LINE_LEN = ST_NEW + 1;

    typedef struct packed {
        logic [30:0] base;
        logic [31:0] amp;
        logic [30:0] freq;
    } t_rad_cfg;

    // one word as it travels down the main line
    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][32:0] d;
        logic             far;
        logic [2:0][63:0] sq;
        logic [63:0]      sum;
        logic [31:0]      r;
        logic [61:0]      rr;
        logic             rpos;
        logic             push;
        logic [31:0]      m;
        logic [2:0][63:0] prod;
        logic [2:0][31:0] np;
    } t_item;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [33:0] cordic_atan(input logic [3:0] i);
        logic signed [33:0] v;
        case (i)
            4'd0:  v = 34'sd536870912;
            4'd1:  v = 34'sd316933406;
            4'd2:  v = 34'sd167458907;
            4'd3:  v = 34'sd85004756;
            4'd4:  v = 34'sd42667331;
            4'd5:  v = 34'sd21354465;
            4'd6:  v = 34'sd10679838;
            4'd7:  v = 34'sd5340245;
            4'd8:  v = 34'sd2670163;
            4'd9:  v = 34'sd1335087;
            4'd10: v = 34'sd667544;
            4'd11: v = 34'sd333772;
            4'd12: v = 34'sd166886;
            4'd13: v = 34'sd83443;
            4'd14: v = 34'sd41722;
            4'd15: v = 34'sd20861;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // clamp to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] o;
        if (v > 40'sd2147483647) begin
            o = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            o = 32'h8000_0000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

endpackage

// File: design/psp_radius.sv
`timescale 1ns / 1ps
module psp_radius (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_time,
    input  psp_pkg::t_rad_cfg i_cfg,
    output logic [31:0]       o_radius
);
    import psp_pkg::*;

    logic [15:0]        r_phase;
    logic signed [33:0] r_x [CORDIC_STAGES+1];
    logic signed [33:0] r_y [CORDIC_STAGES+1];
    logic signed [33:0] r_a [CORDIC_STAGES+1];
    logic               r_neg [CORDIC_STAGES+1];
    logic signed [63:0] r_prod;
    logic [31:0]        r_radius;

    logic [31:0]        n_ph;
    logic signed [33:0] n_x [CORDIC_STAGES+1];
    logic signed [33:0] n_y [CORDIC_STAGES+1];
    logic signed [33:0] n_a [CORDIC_STAGES+1];
    logic               n_neg [CORDIC_STAGES+1];
    logic signed [63:0] n_prod;
    logic [31:0]        n_radius;

    // phase, fold into a quarter turn, CORDIC iterations
    always_comb begin
        logic signed [33:0] a0;
        logic signed [33:0] x, y, a, xs, ys;
        int i;
        // only the low 32 bits of the product carry the phase
        n_ph = i_cfg.freq * i_time;
        a0 = $signed({{2{r_phase[15]}}, r_phase, 16'h0000});
        n_neg[0] = 1'b0;
        if (a0 > 34'sd1073741824) begin
            a0 = a0 - 34'sd2147483648;
            n_neg[0] = 1'b1;
        end else if (a0 < -34'sd1073741824) begin
            a0 = a0 + 34'sd2147483648;
            n_neg[0] = 1'b1;
        end
        n_a[0] = a0;
        n_x[0] = CORDIC_GAIN;
        n_y[0] = '0;
        for (int s = 0; s < CORDIC_STAGES; s++) begin
            x = r_x[s];
            y = r_y[s];
            a = r_a[s];
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
                i = s * CORDIC_PER_STAGE + j;
                xs = x >>> i;
                ys = y >>> i;
                if (a >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    a = a - cordic_atan(4'(i));
                end else begin
                    x = x + ys;
                    y = y - xs;
                    a = a + cordic_atan(4'(i));
                end
            end
            n_x[s+1] = x;
            n_y[s+1] = y;
            n_a[s+1] = a;
            n_neg[s+1] = r_neg[s];
        end
    end

    // 1 - cos scaled by amplitude, then radius
    always_comb begin
        logic signed [33:0] c;
        logic signed [34:0] w_t;
        logic [31:0]        w;
        logic signed [64:0] p_t;
        logic signed [63:0] sh;
        logic signed [33:0] rs;
        c = r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
        w_t = 35'sd1073741824 - {c[33], c};
        if (w_t < 0) begin
            w = '0;
        end else if (w_t > 35'sd2147483648) begin
            w = 32'h8000_0000;
        end else begin
            w = w_t[31:0];
        end
        p_t = $signed(i_cfg.amp) * $signed({1'b0, w});
        n_prod = p_t[63:0];
        sh = r_prod >>> 31;
        rs = $signed({3'b000, i_cfg.base}) + $signed(sh[33:0]);
        n_radius = sat32({{6{rs[33]}}, rs});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= n_ph[31:16];
            for (int s = 0; s <= CORDIC_STAGES; s++) begin
                r_x[s]   <= n_x[s];
                r_y[s]   <= n_y[s];
                r_a[s]   <= n_a[s];
                r_neg[s] <= n_neg[s];
            end
            r_prod   <= n_prod;
            r_radius <= n_radius;
        end
    end

    assign o_radius = r_radius;

endmodule

// File: design/psp_sqrt.sv
`timescale 1ns / 1ps
module psp_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    import psp_pkg::*;

    logic [33:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    logic [63:0] r_val  [SQRT_STAGES];
    logic [33:0] n_rem  [SQRT_STAGES];
    logic [31:0] n_root [SQRT_STAGES];
    logic [63:0] n_val  [SQRT_STAGES];

    // restoring square root, two bits of root per stage
    always_comb begin
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] val;
        logic [35:0] t;
        logic [35:0] trial;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                rem = '0;
                root = '0;
                val = i_val;
            end else begin
                rem = r_rem[s-1];
                root = r_root[s-1];
                val = r_val[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                t = {rem, val[63:62]};
                trial = {2'b00, root, 2'b01};
                val = {val[61:0], 2'b00};
                if (t >= trial) begin
                    rem = 34'(t - trial);
                    root = {root[30:0], 1'b1};
                end else begin
                    rem = t[33:0];
                    root = {root[30:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_root[s] = root;
            n_val[s] = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_val[s]  <= n_val[s];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// File: design/psp_div.sv
`timescale 1ns / 1ps
module psp_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_mag,
    output logic        o_neg
);
    import psp_pkg::*;

    logic [31:0] r_rem [DIV_STAGES];
    logic [31:0] r_lq  [DIV_STAGES];
    logic [31:0] r_den [DIV_STAGES];
    logic        r_neg [DIV_STAGES];
    logic [31:0] n_rem [DIV_STAGES];
    logic [31:0] n_lq  [DIV_STAGES];
    logic [31:0] n_den [DIV_STAGES];
    logic        n_neg [DIV_STAGES];

    // signed dividend by magnitude, quotient truncates toward zero
    always_comb begin
        logic [63:0] mag;
        logic [31:0] rem, lq, den;
        logic        ng;
        logic [32:0] t;
        logic        ge;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                ng = i_num[63];
                mag = ng ? 64'(-i_num) : i_num;
                rem = mag[63:32];
                lq = mag[31:0];
                den = i_den;
            end else begin
                rem = r_rem[s-1];
                lq = r_lq[s-1];
                den = r_den[s-1];
                ng = r_neg[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                t = {rem, lq[31]};
                ge = (t >= {1'b0, den});
                rem = ge ? 32'(t - {1'b0, den}) : t[31:0];
                lq = {lq[30:0], ge};
            end
            n_rem[s] = rem;
            n_lq[s] = lq;
            n_den[s] = den;
            n_neg[s] = ng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_lq[s]  <= n_lq[s];
                r_den[s] <= n_den[s];
                r_neg[s] <= n_neg[s];
            end
        end
    end

    assign o_mag = r_lq[DIV_STAGES-1];
    assign o_neg = r_neg[DIV_STAGES-1];

endmodule

// File: design/pulsating_sphere_point_push.sv
`timescale 1ns / 1ps
// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | i_in_valid / o_in_stall   | i_sim_time, i_point_x/y/z
// output   | o_out_valid / i_out_stall | o_new_x/y/z, o_was_pushed, o_sphere_radius
// config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word per cycle while the output word is not stalled.
// The line length is set by the 32-step square root and the 32-step divide, two steps a stage.
// Reset clears the valid bits and loads the register reset values.
// A stalled output word freezes the whole pipeline; input stalls only then.
module pulsating_sphere_point_push (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_sim_time,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_new_x,
    output logic [31:0] o_new_y,
    output logic [31:0] o_new_z,
    output logic        o_was_pushed,
    output logic [31:0] o_sphere_radius,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import psp_pkg::*;

    logic [30:0] r_base;
    logic [31:0] r_amp;
    logic [30:0] r_freq;
    logic [31:0] r_cx, r_cy, r_cz;

    logic [LINE_LEN-1:0] r_vld;
    t_item               r_ln [LINE_LEN];
    t_item               n_ln [LINE_LEN];

    logic        en;
    t_rad_cfg    rad_cfg;
    logic [31:0] radius;
    logic [31:0] root;
    logic [31:0] q_mag [3];
    logic        q_neg [3];

    assign en = !(r_vld[LINE_LEN-1] && i_out_stall);
    assign o_in_stall = !en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 31'd65536;
            r_amp  <= '0;
            r_freq <= 31'd65536;
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_RADIUS: r_base <= i_cfg_data[30:0];
                CFG_PULSE_AMP:   r_amp  <= i_cfg_data;
                CFG_PULSE_FREQ:  r_freq <= i_cfg_data[30:0];
                CFG_CENTER_X:    r_cx   <= i_cfg_data;
                CFG_CENTER_Y:    r_cy   <= i_cfg_data;
                CFG_CENTER_Z:    r_cz   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rad_cfg = '{base: r_base, amp: r_amp, freq: r_freq};

    psp_radius u_radius (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_time   (i_sim_time),
        .i_cfg    (rad_cfg),
        .o_radius (radius)
    );

    psp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_ln[ST_SUM].sum),
        .o_root (root)
    );

    for (genvar a = 0; a < 3; a++) begin : g_div
        psp_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_ln[ST_PROD].prod[a]),
            .i_den (r_ln[ST_PROD].m),
            .o_mag (q_mag[a]),
            .o_neg (q_neg[a])
        );
    end

    // main line: each stage copies the last and adds its own part
    always_comb begin
        logic [31:0]        pin [3];
        logic [31:0]        cen [3];
        logic signed [32:0] d_t;
        logic signed [65:0] sq_t;
        logic signed [32:0] diff_t;
        logic signed [65:0] pr_t;
        logic signed [33:0] q_t;
        logic signed [34:0] s_t;
        logic               far;
        pin[0] = i_point_x;
        pin[1] = i_point_y;
        pin[2] = i_point_z;
        cen[0] = r_cx;
        cen[1] = r_cy;
        cen[2] = r_cz;
        n_ln[0] = '0;
        far = 1'b0;
        for (int a = 0; a < 3; a++) begin
            d_t = $signed({pin[a][31], pin[a]}) - $signed({cen[a][31], cen[a]});
            n_ln[ST_D].p[a] = pin[a];
            n_ln[ST_D].d[a] = d_t;
            // |d| of 2^31 or more lies outside any radius
            if ((d_t[32] ^ d_t[31]) || (d_t == {2'b11, 31'd0})) begin
                far = 1'b1;
            end
        end
        n_ln[ST_D].far = far;
        for (int k = 1; k < LINE_LEN; k++) begin
            n_ln[k] = r_ln[k-1];
        end
        for (int a = 0; a < 3; a++) begin
            sq_t = $signed(r_ln[ST_SQ-1].d[a]) * $signed(r_ln[ST_SQ-1].d[a]);
            n_ln[ST_SQ].sq[a] = sq_t[63:0];
        end
        n_ln[ST_SUM].sum = r_ln[ST_SUM-1].sq[0] + r_ln[ST_SUM-1].sq[1]
                         + r_ln[ST_SUM-1].sq[2];
        n_ln[ST_R].r = radius;
        n_ln[ST_RR].rr = r_ln[ST_RR-1].r[30:0] * r_ln[ST_RR-1].r[30:0];
        n_ln[ST_RR].rpos = !r_ln[ST_RR-1].r[31] && (r_ln[ST_RR-1].r != '0);
        n_ln[ST_PUSH].push = !r_ln[ST_PUSH-1].far && r_ln[ST_PUSH-1].rpos
                           && (r_ln[ST_PUSH-1].sum != '0)
                           && (r_ln[ST_PUSH-1].sum < {2'b00, r_ln[ST_PUSH-1].rr});
        n_ln[ST_M].m = root;
        diff_t = $signed({r_ln[ST_PROD-1].r[31], r_ln[ST_PROD-1].r})
               - $signed({1'b0, r_ln[ST_PROD-1].m});
        for (int a = 0; a < 3; a++) begin
            pr_t = diff_t * $signed(r_ln[ST_PROD-1].d[a]);
            n_ln[ST_PROD].prod[a] = pr_t[63:0];
        end
        // apply the offset to pushed words and saturate; other words keep their point
        for (int a = 0; a < 3; a++) begin
            q_t = q_neg[a] ? -$signed({2'b00, q_mag[a]}) : $signed({2'b00, q_mag[a]});
            s_t = $signed({{3{r_ln[ST_NEW-1].p[a][31]}}, r_ln[ST_NEW-1].p[a]})
                + $signed({q_t[33], q_t});
            n_ln[ST_NEW].np[a] = r_ln[ST_NEW-1].push ? sat32({{5{s_t[34]}}, s_t})
                                                     : r_ln[ST_NEW-1].p[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LINE_LEN-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < LINE_LEN; k++) begin
                r_ln[k] <= n_ln[k];
            end
        end
    end

    assign o_out_valid     = r_vld[LINE_LEN-1];
    assign o_new_x         = r_ln[LINE_LEN-1].np[0];
    assign o_new_y         = r_ln[LINE_LEN-1].np[1];
    assign o_new_z         = r_ln[LINE_LEN-1].np[2];
    assign o_was_pushed    = r_ln[LINE_LEN-1].push;
    assign o_sphere_radius = r_ln[LINE_LEN-1].r;

    // input only held back behind a waiting output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output word waiting");

    // a held pipeline keeps every valid bit
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // a pushed point needs a positive radius
    a_push_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_pushed) |-> (!o_sphere_radius[31] && o_sphere_radius != '0))
        else $error("point pushed with non-positive radius");

endmodule

// File: dv/tb_pulsating_sphere_point_push.sv
`timescale 1ns / 1ps
module tb_pulsating_sphere_point_push;
    import psp_pkg::*;

    typedef struct {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        pushed;
        logic [31:0] radius;
    } t_push_word;

    // sphere settings as last written
    logic [30:0]        base_r = 31'd65536;
    logic signed [31:0] amp_r  = 32'sd0;
    logic [30:0]        freq_r = 31'd65536;
    logic signed [31:0] cen[3] = '{32'sd0, 32'sd0, 32'sd0};

    int fail_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_cnt++;
    endtask

    // floor shift for signed 64-bit values
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint cos_of_turn(input logic [31:0] ang);
        longint a, x, y, xs, ys;
        logic [33:0] at;
        bit neg;
        a = ang;
        neg = 0;
        x = 652032874;
        y = 0;
        if (a >= 64'sd2147483648) a -= 64'sd4294967296;
        if (a > 64'sd1073741824) begin
            a -= 64'sd2147483648; neg = 1;
        end else if (a < -64'sd1073741824) begin
            a += 64'sd2147483648; neg = 1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            at = cordic_atan(i[3:0]);
            if (a >= 0) begin
                x -= ys; y += xs; a -= longint'(at);
            end else begin
                x += ys; y -= xs; a += longint'(at);
            end
        end
        return neg ? -x : x;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_push_word predict_push(input logic [31:0] t,
                                                input logic [31:0] px,
                                                input logic [31:0] py,
                                                input logic [31:0] pz);
        t_push_word o;
        longint p[3], d[3], nv[3], c, w, r, m;
        longint unsigned ph, sum;
        bit far;
        p[0] = longint'($signed(px));
        p[1] = longint'($signed(py));
        p[2] = longint'($signed(pz));
        ph = ((longint'(freq_r) * longint'(t)) >> 16) & 64'hFFFF;
        c = cos_of_turn({ph[15:0], 16'h0});
        w = 64'sd1073741824 - c;
        if (w < 0) w = 0;
        if (w > 64'sd2147483648) w = 64'sd2147483648;
        r = clamp32(longint'(base_r) + floor_shift(longint'(amp_r) * w, 31));
        far = 0;
        sum = 0;
        o.pushed = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = p[k] - longint'(cen[k]);
            nv[k] = p[k];
            if (d[k] >= 64'sd2147483648 || d[k] <= -64'sd2147483648) far = 1;
        end
        if (!far && r > 0) begin
            for (int k = 0; k < 3; k++) sum += longint'(d[k] * d[k]);
            if (sum != 0 && sum < longint'(r * r)) begin
                m = longint'(root_floor(sum));
                o.pushed = 1;
                for (int k = 0; k < 3; k++)
                    nv[k] = clamp32(p[k] + ((r - m) * d[k]) / m);
            end
        end
        o.nx = nv[0][31:0];
        o.ny = nv[1][31:0];
        o.nz = nv[2][31:0];
        o.radius = r[31:0];
        return o;
    endfunction

    // expected words in order of acceptance
    class push_scoreboard;
        t_push_word pending[$];

        function void note_word(input logic [31:0] t, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
            pending.push_back(predict_push(t, x, y, z));
        endfunction

        task check_word(input t_push_word got);
            t_push_word want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", got.nx, 32'h0);
            end else begin
                want = pending.pop_front();
                if (got.nx !== want.nx) report_mismatch("new_x", got.nx, want.nx);
                if (got.ny !== want.ny) report_mismatch("new_y", got.ny, want.ny);
                if (got.nz !== want.nz) report_mismatch("new_z", got.nz, want.nz);
                if (got.pushed !== want.pushed)
                    report_mismatch("was_pushed", 32'(got.pushed), 32'(want.pushed));
                if (got.radius !== want.radius)
                    report_mismatch("sphere_radius", got.radius, want.radius);
            end
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [31:0] i_sim_time = 0;
    logic [31:0] i_point_x = 0;
    logic [31:0] i_point_y = 0;
    logic [31:0] i_point_z = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [31:0] o_new_x, o_new_y, o_new_z, o_sphere_radius;
    logic        o_was_pushed;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;

    push_scoreboard sb = new();
    int stall_mode = 0;

    pulsating_sphere_point_push uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // output side check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word('{o_new_x, o_new_y, o_new_z, o_was_pushed, o_sphere_radius});
    end

    // receiver stall pattern, mode changed per phase
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // one write; the enable drops before the next may start
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
        case (idx)
            CFG_BASE_RADIUS: base_r = val[30:0];
            CFG_PULSE_AMP:   amp_r = val;
            CFG_PULSE_FREQ:  freq_r = val[30:0];
            CFG_CENTER_X:    cen[0] = val;
            CFG_CENTER_Y:    cen[1] = val;
            CFG_CENTER_Z:    cen[2] = val;
            default: ;
        endcase
    endtask

    // one word; valid stays high when the next follows at once
    task automatic send_word(input logic [31:0] t, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input bit keep);
        i_in_valid <= 1; i_sim_time <= t;
        i_point_x <= x; i_point_y <= y; i_point_z <= z;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(t, x, y, z);
        @(negedge i_clk);
        if (!keep) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_all();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(input logic [31:0] base, input int span);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return base + $urandom_range(0, span) - span / 2;
            2: return base + ($urandom_range(0, span) - span / 2) * 16;
            default: return base + $urandom_range(0, span * 2) - span;
        endcase
    endfunction

    // n words in random bursts, mostly around the current centre
    task automatic random_words(input int n);
        int left, burst, span;
        logic [31:0] t;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            for (int b = 0; b < burst; b++) begin
                span = (base_r > 31'd1000000) ? int'(base_r[30:2]) : 300000;
                t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
                send_word(t, rnd_coord(cen[0], span), rnd_coord(cen[1], span),
                          rnd_coord(cen[2], span), b != burst - 1);
            end
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reset settings, field extremes, centre point, far point
        send_word(0, 0, 0, 0, 0);
        send_word(0, 32'h0000_4000, 0, 0, 0);
        send_word(32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
        send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_word(32'h0000_4000, 32'hFFFF_F000, 32'h0000_1000, 32'hFFFF_FFFF, 0);
        drain_all();
        write_reg(CFG_PULSE_AMP, 32'h0002_0000);
        write_reg(CFG_CENTER_X, 32'h0010_0000);
        write_reg(CFG_CENTER_Y, 32'hFFF0_0000);
        write_reg(CFG_CENTER_Z, 32'h8000_0000);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_word(32'h0000_8000, 32'h0010_0000, 32'hFFF0_0000, 32'h8000_0000, 1);
        send_word(32'h0000_8000, 32'h0010_8000, 32'hFFF0_0000, 32'h8000_0000, 1);
        send_word(32'h0000_C000, 32'h0010_0001, 32'hFFF0_0001, 32'h8000_0001, 1);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'h8000_0000, 0);
        drain_all();
        // negative radius: nothing inside
        write_reg(CFG_PULSE_AMP, 32'h8000_0000);
        write_reg(CFG_BASE_RADIUS, 32'h0000_0001);
        send_word(32'h0000_8000, 32'h0010_0010, 32'hFFF0_0000, 32'h8000_0000, 0);
        drain_all();
        // huge radius saturates outputs
        write_reg(CFG_BASE_RADIUS, 32'hFFFF_FFFF);
        write_reg(CFG_PULSE_AMP, 32'h7FFF_FFFF);
        write_reg(CFG_PULSE_FREQ, 32'hFFFF_FFFF);
        send_word(32'h0001_2345, 32'h0010_0001, 32'hFFF0_0000, 32'h8000_0000, 1);
        send_word(32'hFFFF_FFFF, 32'h0010_0000, 32'hFFF0_0007, 32'h8000_0000, 0);
        drain_all();

        // random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 3;
            write_reg(CFG_BASE_RADIUS, (ph == 7) ? 32'h7FFF_FFFF :
                      (ph == 6) ? 32'h0 : $urandom_range(32'h8000, 32'h00A0_0000));
            write_reg(CFG_PULSE_AMP, (ph == 5) ? 32'h8000_0000 :
                      $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
            write_reg(CFG_PULSE_FREQ, (ph == 4) ? 32'h0 : $urandom);
            write_reg(CFG_CENTER_X, (ph == 3) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 24));
            write_reg(CFG_CENTER_Y, $urandom);
            write_reg(CFG_CENTER_Z, (ph == 2) ? 32'h8000_0000 : $urandom_range(0, 1 << 20));
            random_words(60);
            drain_all();
            random_words(60);
            drain_all();
        end

        drain_all();
        if (fail_cnt == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
design/psp_pkg.sv
design/psp_radius.sv
design/psp_sqrt.sv
design/psp_div.sv
design/pulsating_sphere_point_push.sv
dv/tb_pulsating_sphere_point_push.sv
